@@ hw/rtl/bpc_pkg.sv @@
// bpc_pkg: shared types, codes and constants of the button press classifier
// depends on nothing; imported by bpc_button and button_press_classifier_unit
package bpc_pkg;

   localparam int INTERVAL_W  = 8;
   localparam int TIMER_W     = 16;
   localparam int EVT_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 8'd50;
   localparam logic [TIMER_W-1:0]    DOUBLE_WINDOW_RST   = 16'd300;
   localparam logic [TIMER_W-1:0]    LONG_TIME_RST       = 16'd1000;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_WINDOW   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_TIME       = 2'd2;

   // per-button classification progress
   typedef enum logic [2:0] {
      PROG_IDLE   = 3'd0,
      PROG_FIRST  = 3'd1,
      PROG_SINGLE = 3'd4,
      PROG_LONG   = 3'd5,
      PROG_DOUBLE = 3'd6
   } progress_type;

   // reported event codes
   typedef enum logic [EVT_W-1:0] {
      EVT_NONE   = 2'd0,
      EVT_SINGLE = 2'd1,
      EVT_DOUBLE = 2'd2,
      EVT_LONG   = 2'd3
   } event_type;

   // controls shared by all button slices
   typedef struct packed {
      logic               fire;
      logic               sample;
      logic [TIMER_W-1:0] long_time;
      logic [TIMER_W-1:0] threshold;
   } button_ctrl_type;

   function automatic logic is_pending(input progress_type p);
      return (p == PROG_SINGLE) || (p == PROG_LONG) || (p == PROG_DOUBLE);
   endfunction

   function automatic event_type code_of(input progress_type p);
      event_type c;
      case (p)
         PROG_SINGLE: c = EVT_SINGLE;
         PROG_DOUBLE: c = EVT_DOUBLE;
         PROG_LONG:   c = EVT_LONG;
         default:     c = EVT_NONE;
      endcase
      return c;
   endfunction

endpackage

@@ hw/rtl/bpc_button.sv @@
// bpc_button: state and next-state logic of one button (progress, timer, last level)
// depends on bpc_pkg
module bpc_button
   import bpc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  button_ctrl_type ctrl,
   input  logic            level,
   input  logic            ack,
   output event_type       event_code
);

   progress_type       progress_ff, progress_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               last_level_ff, last_level_in;

   progress_type       prog_ack;
   logic [TIMER_W-1:0] timer_s;

   always_comb begin
      prog_ack      = (ack && is_pending(progress_ff)) ? PROG_IDLE : progress_ff;
      progress_in   = prog_ack;
      timer_s       = timer_ff;
      last_level_in = last_level_ff;
      if (ctrl.sample) begin
         last_level_in = level;
         // press edge, ignored while an event is pending
         if (last_level_ff && !level && !is_pending(prog_ack)) begin
            case (prog_ack)
               PROG_IDLE: begin
                  progress_in = PROG_FIRST;
                  timer_s     = ctrl.long_time;
               end
               PROG_FIRST: begin
                  progress_in = (timer_ff > ctrl.threshold) ? PROG_DOUBLE : PROG_SINGLE;
               end
               default: ;
            endcase
         end
         if (progress_in == PROG_FIRST && timer_s == '0) begin
            progress_in = PROG_LONG;
         end
         if (progress_in == PROG_FIRST && timer_s < ctrl.threshold && level) begin
            progress_in = PROG_SINGLE;
         end
      end
      timer_in = (timer_s == '0) ? timer_s : timer_s - TIMER_W'(1);
   end

   assign event_code = code_of(progress_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff   <= PROG_IDLE;
         timer_ff      <= '0;
         last_level_ff <= 1'b0;
      end else if (ctrl.fire) begin
         progress_ff   <= progress_in;
         timer_ff      <= timer_in;
         last_level_ff <= last_level_in;
      end
   end

endmodule

@@ hw/rtl/button_press_classifier_unit.sv @@
// button_press_classifier_unit: top level, input register, sample countdown,
// csr registers, result register; depends on bpc_pkg and bpc_button
//
//   channel | direction | word
//   --------+-----------+----------------------------------------------------
//   req     | in        | one tick: button levels, acknowledges
//   rsp     | out       | one word per tick: 2-bit event code per button
//   csr     | in        | register write: index, data
//
// one word per cycle sustained while rsp is not stalled; a rsp word passes the input
// register and is then classified into the result register
// the result register frees in the same cycle rsp takes its word, so the
// input register and req_tready keep moving while rsp is not stalled
// a rsp stall holds both stages; req_tready drops once the input register fills
// synchronous active-high reset: csr registers to defaults, buttons idle,
// sample countdown zero (first tick samples), both stages empty
module button_press_classifier_unit
   import bpc_pkg::*;
#(
   parameter int BUTTONS = 2
)(
   input  logic                                   clock,
   input  logic                                   reset,
   // req tdata: button_levels [BUTTONS-1:0], acknowledges [2*BUTTONS-1:BUTTONS], zero fill
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((2*BUTTONS+7)/8)*8-1:0]         req_tdata,
   // rsp tdata: button_events [2*BUTTONS-1:0] (2 bits per button), zero fill
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2*BUTTONS*EVT_W/2+7)/8)*8-1:0] rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_INDEX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata
);

   localparam int IN_W  = 2*BUTTONS;
   localparam int EV_W  = EVT_W*BUTTONS;

   // csr registers
   logic [INTERVAL_W-1:0] sample_interval_ff;
   logic [TIMER_W-1:0]    double_window_ff;
   logic [TIMER_W-1:0]    long_time_ff;

   // input register
   logic                  s1_valid_ff;
   logic [IN_W-1:0]       s1_data_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [EV_W-1:0]       rsp_events_ff;

   logic [INTERVAL_W-1:0] countdown_ff, countdown_in;
   logic [INTERVAL_W-1:0] countdown_dec;
   logic                  sample;
   logic                  out_free;
   logic                  fire;
   logic [EV_W-1:0]       events;
   button_ctrl_type       button_ctrl;

   // handshake: result slot frees as rsp takes its word
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata         = '0;
      rsp_tdata[EV_W-1:0] = rsp_events_ff;
   end

   // csr writes, always accepted; the sender must issue them only with no word in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_interval_ff <= SAMPLE_INTERVAL_RST;
         double_window_ff   <= DOUBLE_WINDOW_RST;
         long_time_ff       <= LONG_TIME_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: sample_interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_DOUBLE_WINDOW:   double_window_ff   <= csr_wdata;
            CSR_LONG_TIME:       long_time_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared sample countdown: decrement, sample and reload on reaching zero
   always_comb begin
      countdown_dec = (countdown_ff == '0) ? countdown_ff : countdown_ff - INTERVAL_W'(1);
      sample        = (countdown_dec == '0);
      countdown_in  = sample ? sample_interval_ff : countdown_dec;
   end

   // double threshold saturates at zero when the window covers the hold time
   always_comb begin
      button_ctrl.fire      = fire;
      button_ctrl.sample    = sample;
      button_ctrl.long_time = long_time_ff;
      button_ctrl.threshold = (double_window_ff >= long_time_ff) ? '0
                              : long_time_ff - double_window_ff;
   end

   for (genvar b = 0; b < BUTTONS; b++) begin : g_button
      event_type code;
      bpc_button u_button (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (button_ctrl),
         .level      (s1_data_ff[b]),
         .ack        (s1_data_ff[BUTTONS+b]),
         .event_code (code)
      );
      assign events[EVT_W*b +: EVT_W] = code;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         countdown_ff <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (fire) begin
            countdown_ff <= countdown_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata[IN_W-1:0];
      end
      if (fire) begin
         rsp_events_ff <= events;
      end
   end

`ifndef ASSERT_OFF
   // a new result only comes from a filled input register
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) && !s1_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared without an input word");

   // req is only blocked by a full input register behind a stalled result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("req blocked without a stall");

   // a sampling tick reloads the countdown with the interval
   a_reload: assert property (@(posedge clock) disable iff (reset)
      fire && sample |=> countdown_ff == $past(sample_interval_ff))
      else $error("countdown not reloaded on sample");

   // countdown holds while no tick is processed
   a_countdown_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(countdown_ff))
      else $error("countdown moved without a tick");
`endif

endmodule

@@ tb/button_press_classifier_unit_tb.sv @@
// button_press_classifier_unit_tb: self-checking bench for the button press classifier
// drives tick words with random gaps and rsp stalls, predicts every rsp word in a
// scoreboard class; depends on bpc_pkg and button_press_classifier_unit
module button_press_classifier_unit_tb;
   import bpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBTN         = 2;
   localparam int HOLD_CYCLES  = 48;     // long rsp stall to back up the pipe
   localparam int HOLD_AFTER   = 250;    // words checked before that stall
   localparam int DRAIN_LIMIT  = 5000;   // cycles allowed for outstanding words
   localparam int DRAIN_CYCLES = 4;      // two-stage pipe plus margin
   localparam int MAX_REPORTS  = 10;
   localparam int SEG_CAP      = 300;    // longest level segment in ticks

   // ---------------------------------------------------------------------
   // scoreboard: tick-by-tick classifier predictor and queue of event words
   // ---------------------------------------------------------------------
   class press_scoreboard;
      logic [INTERVAL_W-1:0] interval;
      logic [TIMER_W-1:0]    window;
      logic [TIMER_W-1:0]    hold_time;
      logic [INTERVAL_W-1:0] countdown;
      progress_type          prog [NBTN];
      logic [TIMER_W-1:0]    timer [NBTN];
      logic                  prev_level [NBTN];
      logic [2*NBTN-1:0]     pending_events [$];
      int words_noted, words_checked, failures, reports;
      int n_single, n_double, n_long;

      function new();
         interval  = SAMPLE_INTERVAL_RST;
         window    = DOUBLE_WINDOW_RST;
         hold_time = LONG_TIME_RST;
         countdown = '0;
         for (int b = 0; b < NBTN; b++) begin
            prog[b]       = PROG_IDLE;
            timer[b]      = '0;
            prev_level[b] = 1'b0;
         end
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_INTERVAL: interval  = data[INTERVAL_W-1:0];
            CSR_DOUBLE_WINDOW:   window    = data;
            CSR_LONG_TIME:       hold_time = data;
            default: ;
         endcase
      endfunction

      function bit awaiting_ack(progress_type p);
         return p == PROG_SINGLE || p == PROG_LONG || p == PROG_DOUBLE;
      endfunction

      function bit awaiting(int b);
         return awaiting_ack(prog[b]);
      endfunction

      function event_type code_for(progress_type p);
         event_type c;
         c = EVT_NONE;
         if (p == PROG_SINGLE) c = EVT_SINGLE;
         else if (p == PROG_DOUBLE) c = EVT_DOUBLE;
         else if (p == PROG_LONG) c = EVT_LONG;
         return c;
      endfunction

      // one debounced sample of one button
      function void sample_button(int b, logic lvl);
         logic [TIMER_W-1:0] thr;
         progress_type p;
         thr = (window >= hold_time) ? '0 : hold_time - window;
         p = prog[b];
         if (prev_level[b] && !lvl) begin
            prev_level[b] = 1'b0;
            if (awaiting_ack(p)) return;   // press swallowed while an event waits
            if (p == PROG_IDLE) begin
               p = PROG_FIRST;
               timer[b] = hold_time;
            end else if (p == PROG_FIRST) begin
               if (timer[b] > thr) p = PROG_DOUBLE;
               else p = PROG_SINGLE;
            end
         end
         if (p == PROG_FIRST && timer[b] == '0) p = PROG_LONG;
         if (p == PROG_FIRST && timer[b] < thr && lvl) p = PROG_SINGLE;
         if (p != prog[b]) begin
            case (p)
               PROG_SINGLE: n_single++;
               PROG_DOUBLE: n_double++;
               PROG_LONG:   n_long++;
               default: ;
            endcase
         end
         prog[b] = p;
         prev_level[b] = lvl;
      endfunction

      // one accepted tick word: acks, countdown and samples, timers, then report
      function void note_input(logic [NBTN-1:0] lv, logic [NBTN-1:0] ack);
         logic [2*NBTN-1:0] ev;
         for (int b = 0; b < NBTN; b++)
            if (ack[b] && awaiting_ack(prog[b])) prog[b] = PROG_IDLE;
         if (countdown != '0) countdown--;
         if (countdown == '0) begin
            countdown = interval;
            for (int b = 0; b < NBTN; b++) sample_button(b, lv[b]);
         end
         for (int b = 0; b < NBTN; b++)
            if (timer[b] != '0) timer[b]--;
         for (int b = 0; b < NBTN; b++) ev[2*b +: 2] = code_for(prog[b]);
         pending_events.push_back(ev);
         words_noted++;
      endfunction

      function void note_failure(string msg);
         failures++;
         if (reports < MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
            reports++;
         end
      endfunction

      function void check_word(logic [7:0] word);
         logic [2*NBTN-1:0] ev;
         if (pending_events.size() == 0) begin
            note_failure($sformatf("rsp word 0x%02h with none expected", word));
            return;
         end
         ev = pending_events.pop_front();
         for (int b = 0; b < NBTN; b++)
            if (word[2*b +: 2] !== ev[2*b +: 2])
               note_failure($sformatf("word %0d button %0d: expected %0d got %0d",
                                      words_checked, b, ev[2*b +: 2], word[2*b +: 2]));
         words_checked++;
      endfunction

      function int outstanding();
         return pending_events.size();
      endfunction

      function void close_out();
         if (pending_events.size() != 0)
            note_failure($sformatf("%0d rsp words never arrived", pending_events.size()));
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // clock, reset, dut
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;   // levels [1:0], acks [3:2], zero fill
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [7:0]             rsp_tdata;         // button events [3:0], 2 bits per button
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   always #10 clock = ~clock;

   button_press_classifier_unit #(.BUTTONS(NBTN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   press_scoreboard sb;
   bit pressure_done = 1'b0;
   bit timed_out     = 1'b0;
   int settings_run  = 0;

   // stimulus shaping for the current setting
   int cur_si, cur_dw, cur_lt;
   logic seg_level [NBTN];
   int   seg_left  [NBTN];

   // {acks, levels}: double on button 0, ack of it, long on button 1 with a
   // single on button 0 alongside, press while pending, acks with nothing
   // pending, ack on the tick of a press edge, second double on button 0
   logic [3:0] warmup_words [0:19] = '{
      4'b0011, 4'b0010, 4'b0011, 4'b0010, 4'b0111,
      4'b1001, 4'b0000, 4'b0001, 4'b0001, 4'b0001,
      4'b0001, 4'b0001, 4'b0000, 4'b1111, 4'b1111,
      4'b0110, 4'b0011, 4'b0000, 4'b0011, 4'b0111
   };

   // ---------------------------------------------------------------------
   // driver tasks
   // ---------------------------------------------------------------------

   // one register write; csr_valid is left high for a following write
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   task automatic configure(int si, int dw, int lt);
      cur_si = si;
      cur_dw = dw;
      cur_lt = lt;
      write_csr(CSR_SAMPLE_INTERVAL, CSR_DATA_W'(si));
      write_csr(CSR_DOUBLE_WINDOW, CSR_DATA_W'(dw));
      write_csr(CSR_LONG_TIME, CSR_DATA_W'(lt));
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // offer one tick word and wait for it to be taken; tvalid stays high
   task automatic send_word(logic [NBTN-1:0] lv, logic [NBTN-1:0] ack);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, ack, lv};
      do @(posedge clock); while (!req_tready);
      sb.note_input(lv, ack);
   endtask

   // next level segment length, scaled to the sample interval and windows
   function automatic int segment_ticks();
      int r, d, hi;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         hi = (cur_dw / 2 > cur_si) ? cur_dw / 2 : cur_si;
         d = $urandom_range(1, hi);
      end else if (r < 7) begin
         d = $urandom_range(cur_si, cur_lt > cur_si ? cur_lt : cur_si);
      end else if (r < 9) begin
         d = cur_lt + $urandom_range(cur_si, 3 * cur_si);
      end else begin
         d = 1;
      end
      return (d > SEG_CAP) ? SEG_CAP : d;
   endfunction

   // mostly clean press/release segments, some one-tick glitches, acks that
   // are more likely while an event is pending
   task automatic pick_tick(output logic [NBTN-1:0] lv, output logic [NBTN-1:0] ack);
      for (int b = 0; b < NBTN; b++) begin
         if (seg_left[b] <= 0) begin
            seg_level[b] = ~seg_level[b];
            seg_left[b]  = segment_ticks();
         end
         seg_left[b]--;
         lv[b] = ($urandom_range(0, 19) == 0) ? ~seg_level[b] : seg_level[b];
         if (sb.awaiting(b)) ack[b] = ($urandom_range(0, 2) == 0);
         else ack[b] = ($urandom_range(0, 9) == 0);
      end
   endtask

   // wait until every predicted word is back, then let the pipe settle
   task automatic wait_drained();
      int n;
      n = 0;
      while (sb.outstanding() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (sb.outstanding() != 0) timed_out = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random words in bursts with random gaps, some bursts back to back
   task automatic run_random(int count);
      int left, burst, gap;
      logic [NBTN-1:0] lv, ack;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && left > 0) begin
            pick_tick(lv, ack);
            send_word(lv, ack);
            burst--;
            left--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (left > 0 && gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // rsp side: stall pattern with one long hold, and the word checker
   // ---------------------------------------------------------------------
   initial begin : rsp_stall
      int mode, len;
      @(posedge clock);
      forever begin
         if (!pressure_done && sb.words_checked >= HOLD_AFTER) begin
            // long hold while req keeps offering, so req_tready has to drop
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            pressure_done = 1'b1;
         end
         mode = $urandom_range(0, 2);
         len  = $urandom_range(10, 60);
         repeat (len) begin
            @(posedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   initial begin : rsp_check
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      sb = new();
      for (int b = 0; b < NBTN; b++) begin
         seg_level[b] = 1'b1;
         seg_left[b]  = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fast setting so the warmup words hit every classification; the
      // countdown is zero after reset so the first word already samples
      configure(1, 3, 6);
      foreach (warmup_words[i]) send_word(warmup_words[i][1:0], warmup_words[i][3:2]);
      req_tvalid <= 1'b0;
      wait_drained();

      // low extremes, ordinary settings, window covering the whole hold time,
      // widest window, reset defaults and finally the high extremes
      configure(1, 1, 2);                run_random(40);
      configure(2, 6, 20);               run_random(60);
      configure(1, 40, 30);              run_random(50);
      configure(3, 10, 25);              run_random(60);
      configure(1, 65535, 12);           run_random(40);
      configure($urandom_range(1, 4), $urandom_range(2, 30), $urandom_range(6, 40));
      run_random(60);
      configure(4, 20, 40);              run_random(60);
      configure(SAMPLE_INTERVAL_RST, DOUBLE_WINDOW_RST, LONG_TIME_RST);
      run_random(40);
      configure(255, 65535, 65535);      run_random(40);

      sb.close_out();
      $display("ran %0d tick words under %0d register settings, rsp held off %s",
               sb.words_noted, settings_run, pressure_done ? "once" : "never");
      $display("classified %0d single, %0d double and %0d long presses",
               sb.n_single, sb.n_double, sb.n_long);
      if (sb.failures == 0 && !timed_out) begin
         $display("button_press_classifier_unit_tb: PASS");
      end else begin
         $display("button_press_classifier_unit_tb: FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("button_press_classifier_unit_tb: FAIL");
      $finish;
   end

endmodule
